// File: src/clock_page_replacement_defines.svh
// Assertion helpers shared by the page replacement block
`ifndef CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// Check cons in the same cycle as ante
`define CPR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page replacement check failed");

// Check cons in the cycle after ante
`define CPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page replacement check failed");

`endif

// File: src/cpr_pkg.sv
package cpr_pkg;

  // Default sizing
  localparam int DEF_MAX_FRAMES = 16;
  localparam int DEF_PAGE_BITS  = 16;

  // Register map
  localparam int          ADDR_W         = 3;
  localparam logic        REG_FRAMES_SEL = 1'b0;
  localparam logic [4:0]  FRAMES_RESET   = 5'd16;

  // Operation broadcast down the frame chain
  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_CLEAR,
    CELL_FILL,
    CELL_TOUCH,
    CELL_STRIP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     mod;
  } cell_cmd_t;

  // Status returned by the chain
  typedef struct packed {
    logic found;
    logic target_busy;
  } chain_stat_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP,
    ST_DONE
  } cpr_state_t;

  // Increment that holds at the top
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// File: src/clock_page_replacement.sv
// A hit or a fill is decided in ST_LOOK and goes to the output register, or waits in ST_DONE
// while it is full. A fault on a full table steps the hand once per cycle, at most n+1 steps.
// Throughput: one request at a time; the next one is taken the cycle after the
// result is placed in the output register, while that result waits to be taken.
// Reset (rst, synchronous): clears frame status bits, hand, fill count, counters
// and sets frames_in_use to 16; page contents are not cleared, no sweep needed.
module clock_page_replacement #(
  parameter int MAX_FRAMES = cpr_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = cpr_pkg::DEF_PAGE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  // tdata: page_number[15:0], modified[16], zero fill [23:17]
  input  logic [23:0]                s_tdata,
  // tuser: new_trace[0]
  input  logic [0:0]                 s_tuser,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // tdata: frame_slot[3:0], hit_count[35:4], fault_count[67:36], zero fill [71:68]
  output logic [71:0]                m_tdata,
  // tuser: hit[0]
  output logic [0:0]                 m_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cpr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import cpr_pkg::*;

  `include "clock_page_replacement_defines.svh"

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int CW = (NW > 5) ? NW : 5;
  localparam int EW = (PAGE_BITS > 16) ? PAGE_BITS : 16;

  cpr_state_t           state, state_next;
  logic [4:0]           frames_in_use;
  logic [PAGE_BITS-1:0] page_q;
  logic                 mod_q;
  logic [IW-1:0]        hand, hand_next;
  logic [NW-1:0]        filled_frames, filled_frames_next;
  logic [31:0]          hits_total, hits_total_next;
  logic [31:0]          faults_total, faults_total_next;
  logic                 res_hit, res_hit_next;
  logic [IW-1:0]        res_slot, res_slot_next;
  logic                 out_hit, out_hit_next;
  logic [3:0]           out_slot, out_slot_next;
  logic [31:0]          out_hits, out_hits_next;
  logic [31:0]          out_faults, out_faults_next;
  logic                 m_tvalid_next;

  logic [NW-1:0]        active_n;
  logic [CW-1:0]        fiu_ext;
  logic [IW-1:0]        hand_eff;
  logic [NW-1:0]        hand_inc;
  logic [IW-1:0]        hand_wrap;
  logic [EW-1:0]        page_ext;
  logic                 take_in;
  logic                 out_free;
  logic                 finish;
  logic [IW+3:0]        slot_ext;

  cell_cmd_t            cmd;
  logic [IW-1:0]        target;
  chain_stat_t          stat;
  logic [IW-1:0]        found_idx;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAMES_SEL) ? {27'd0, frames_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAMES_SEL) begin
      frames_in_use <= pwdata[4:0];
    end
  end

  // Clamp the frame count into 1..MAX_FRAMES
  assign fiu_ext = CW'(frames_in_use);
  always_comb begin
    if (frames_in_use == 5'd0) begin
      active_n = NW'(1);
    end else if (fiu_ext > CW'(MAX_FRAMES)) begin
      active_n = NW'(MAX_FRAMES);
    end else begin
      active_n = fiu_ext[NW-1:0];
    end
  end

  // Hand wraps before and after each step
  assign hand_eff  = (NW'(hand) >= active_n) ? '0 : hand;
  assign hand_inc  = NW'(hand_eff) + NW'(1);
  assign hand_wrap = (hand_inc >= active_n) ? '0 : hand_inc[IW-1:0];

  assign page_ext = EW'(s_tdata[15:0]);
  assign take_in  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Frame chain
  cpr_chain #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .target    (target),
    .active_n  (active_n),
    .page      (page_q),
    .stat      (stat),
    .found_idx (found_idx)
  );

  // Latch the request
  always_ff @(posedge clk) begin
    if (take_in) begin
      page_q <= page_ext[PAGE_BITS-1:0];
      mod_q  <= s_tdata[16];
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      hand          <= '0;
      filled_frames <= '0;
      hits_total    <= '0;
      faults_total  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state         <= state_next;
      hand          <= hand_next;
      filled_frames <= filled_frames_next;
      hits_total    <= hits_total_next;
      faults_total  <= faults_total_next;
      m_tvalid      <= m_tvalid_next;
    end
  end

  // Result and output payload
  always_ff @(posedge clk) begin
    res_hit    <= res_hit_next;
    res_slot   <= res_slot_next;
    out_hit    <= out_hit_next;
    out_slot   <= out_slot_next;
    out_hits   <= out_hits_next;
    out_faults <= out_faults_next;
  end

  // Next state and chain commands
  always_comb begin
    state_next         = state;
    hand_next          = hand;
    filled_frames_next = filled_frames;
    hits_total_next    = hits_total;
    faults_total_next  = faults_total;
    res_hit_next       = res_hit;
    res_slot_next      = res_slot;
    cmd.op             = CELL_NOP;
    cmd.mod            = mod_q;
    target             = '0;
    s_tready           = 1'b0;
    finish             = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser[0]) begin
            cmd.op             = CELL_CLEAR;
            hand_next          = '0;
            filled_frames_next = '0;
            hits_total_next    = '0;
            faults_total_next  = '0;
          end
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (stat.found) begin
          target          = found_idx;
          cmd.op          = CELL_TOUCH;
          hits_total_next = sat_inc(hits_total);
          res_hit_next    = 1'b1;
          res_slot_next   = found_idx;
          finish          = 1'b1;
        end else if (filled_frames < active_n) begin
          target             = filled_frames[IW-1:0];
          cmd.op             = CELL_FILL;
          filled_frames_next = filled_frames + NW'(1);
          faults_total_next  = sat_inc(faults_total);
          res_hit_next       = 1'b0;
          res_slot_next      = filled_frames[IW-1:0];
          finish             = 1'b1;
        end else begin
          hand_next  = hand_eff;
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        target    = hand_eff;
        hand_next = hand_wrap;
        if (stat.target_busy) begin
          cmd.op = CELL_STRIP;
        end else begin
          cmd.op            = CELL_FILL;
          faults_total_next = sat_inc(faults_total);
          res_hit_next      = 1'b0;
          res_slot_next     = hand_eff;
          finish            = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    if (finish) begin
      state_next = out_free ? ST_IDLE : ST_DONE;
    end
  end

  // Load the output register from a fresh or a parked result
  always_comb begin
    out_hit_next    = out_hit;
    out_slot_next   = out_slot;
    out_hits_next   = out_hits;
    out_faults_next = out_faults;
    slot_ext        = {4'd0, res_slot_next};
    m_tvalid_next   = m_tready ? 1'b0 : m_tvalid;
    if ((finish || state == ST_DONE) && out_free) begin
      out_hit_next    = res_hit_next;
      out_slot_next   = slot_ext[3:0];
      out_hits_next   = hits_total_next;
      out_faults_next = faults_total_next;
      m_tvalid_next   = 1'b1;
    end
  end

  assign m_tdata = {4'd0, out_faults, out_hits, out_slot};
  assign m_tuser = out_hit;

  // A parked result only exists while the output register is full
  `CPR_ASSERT_NOW(a_done_waits, clk, rst, state == ST_DONE, m_tvalid)
  // The hand only sweeps once every active frame is filled
  `CPR_ASSERT_NOW(a_sweep_full, clk, rst, state == ST_SWEEP, filled_frames >= active_n)
  // The fill count never passes the table size
  `CPR_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, filled_frames <= NW'(MAX_FRAMES))
  // Counters only grow outside the request cycle
  `CPR_ASSERT_NEXT(a_count_grow, clk, rst, state != ST_IDLE,
                   hits_total >= $past(hits_total) && faults_total >= $past(faults_total))

endmodule

// File: src/cpr_cell.sv
module cpr_cell #(
  parameter int PAGE_BITS = cpr_pkg::DEF_PAGE_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cpr_pkg::cell_cmd_t   cmd,
  input  logic                 sel,
  input  logic                 active,
  input  logic [PAGE_BITS-1:0] page_in,
  input  logic                 seen_in,
  output logic                 seen_out,
  output logic                 first,
  output logic                 busy
);
  import cpr_pkg::*;

  logic [PAGE_BITS-1:0] page;
  logic                 valid;
  logic                 ref_bit;
  logic                 mod_bit;
  logic                 match;

  // Compare against the broadcast page and pass the result on
  assign match    = active && valid && (page == page_in);
  assign first    = match && !seen_in;
  assign seen_out = seen_in || match;
  assign busy     = ref_bit || mod_bit;

  // Hold the stored page; load it on fill
  always_ff @(posedge clk) begin
    if (sel && cmd.op == CELL_FILL) begin
      page <= page_in;
    end
  end

  // Update the frame's status bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      ref_bit <= 1'b0;
      mod_bit <= 1'b0;
    end else if (cmd.op == CELL_CLEAR) begin
      valid   <= 1'b0;
      ref_bit <= 1'b0;
      mod_bit <= 1'b0;
    end else if (sel) begin
      case (cmd.op)
        CELL_FILL: begin
          valid   <= 1'b1;
          ref_bit <= 1'b0;
          mod_bit <= cmd.mod;
        end
        CELL_TOUCH: begin
          ref_bit <= 1'b1;
          mod_bit <= cmd.mod;
        end
        CELL_STRIP: begin
          ref_bit <= 1'b0;
          mod_bit <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/cpr_chain.sv
module cpr_chain #(
  parameter int MAX_FRAMES = cpr_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = cpr_pkg::DEF_PAGE_BITS,
  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
  localparam int NW = $clog2(MAX_FRAMES + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cpr_pkg::cell_cmd_t   cmd,
  input  logic [IW-1:0]        target,
  input  logic [NW-1:0]        active_n,
  input  logic [PAGE_BITS-1:0] page,
  output cpr_pkg::chain_stat_t stat,
  output logic [IW-1:0]        found_idx
);
  import cpr_pkg::*;

  logic [MAX_FRAMES:0]   seen;
  logic [MAX_FRAMES-1:0] first;
  logic [MAX_FRAMES-1:0] busy;

  assign seen[0] = 1'b0;

  // Row of frame cells, the match flag ripples from frame 0 upward
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    cpr_cell #(.PAGE_BITS(PAGE_BITS)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .sel      (target == IW'(i)),
      .active   (NW'(i) < active_n),
      .page_in  (page),
      .seen_in  (seen[i]),
      .seen_out (seen[i+1]),
      .first    (first[i]),
      .busy     (busy[i])
    );
  end

  // Encode the first matching frame
  always_comb begin
    found_idx = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (first[i]) found_idx = found_idx | IW'(i);
    end
  end

  assign stat.found       = seen[MAX_FRAMES];
  assign stat.target_busy = busy[target];

endmodule

// File: verif/tb_clock_page_replacement.sv
`timescale 1ns / 100ps

module tb_clock_page_replacement;
  import cpr_pkg::*;

  localparam int FRAMES     = 16;
  localparam int IDLE_LIMIT = 3000;
  localparam int PHASE_REFS = 80;
  localparam logic [ADDR_W-1:0] FRAMES_ADDR = '0;

  typedef struct packed {
    logic [15:0] page;
    logic        mod;
    logic        fresh;
  } page_ref_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic [31:0] hits;
    logic [31:0] faults;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [23:0] s_tdata  = '0;
  logic [0:0]  s_tuser  = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  clock_page_replacement dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the frame table
  logic [15:0] shadow_page [FRAMES];
  logic        shadow_valid [FRAMES];
  logic        shadow_ref [FRAMES];
  logic        shadow_mod [FRAMES];
  int          shadow_hand   = 0;
  int          shadow_filled = 0;
  logic [31:0] shadow_hits   = '0;
  logic [31:0] shadow_faults = '0;
  logic [4:0]  frames_cfg    = 5'd16;

  page_ref_t pending_refs[$];
  outcome_t  outcome_q[$];

  bit       req_taken  = 1'b0;
  int       cyc        = 0;
  int       idle_cycles = 0;
  int       fail_count = 0;
  int       results_seen = 0;
  int       hits_seen  = 0;
  int       sweeps     = 0;
  int       restarts   = 0;
  int       settings_used = 0;

  // Work out the result of one page request and update the shadow table
  function automatic outcome_t replace_page(input logic [15:0] page, input logic mod,
                                            input logic fresh);
    outcome_t r;
    int n;
    int slot;
    bit found;
    if (fresh) begin
      for (int f = 0; f < FRAMES; f++) begin
        shadow_valid[f] = 1'b0;
        shadow_ref[f]   = 1'b0;
        shadow_mod[f]   = 1'b0;
      end
      shadow_hand   = 0;
      shadow_filled = 0;
      shadow_hits   = '0;
      shadow_faults = '0;
      restarts++;
    end
    n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
    found = 1'b0;
    slot  = 0;
    for (int f = 0; f < n; f++) begin
      if (!found && shadow_valid[f] && shadow_page[f] == page) begin
        found = 1'b1;
        slot  = f;
      end
    end
    if (found) begin
      shadow_ref[slot] = 1'b1;
      shadow_mod[slot] = mod;
      if (shadow_hits != 32'hFFFF_FFFF) shadow_hits = shadow_hits + 1;
    end else begin
      if (shadow_filled < n) begin
        slot = shadow_filled;
        shadow_filled++;
      end else begin
        // Sweep the hand, giving used frames a second chance
        sweeps++;
        if (shadow_hand >= n) shadow_hand = 0;
        while (shadow_ref[shadow_hand] || shadow_mod[shadow_hand]) begin
          shadow_ref[shadow_hand] = 1'b0;
          shadow_mod[shadow_hand] = 1'b0;
          shadow_hand++;
          if (shadow_hand >= n) shadow_hand = 0;
        end
        slot = shadow_hand;
        shadow_hand++;
        if (shadow_hand >= n) shadow_hand = 0;
      end
      shadow_page[slot]  = page;
      shadow_valid[slot] = 1'b1;
      shadow_ref[slot]   = 1'b0;
      shadow_mod[slot]   = mod;
      if (shadow_faults != 32'hFFFF_FFFF) shadow_faults = shadow_faults + 1;
    end
    r.hit    = found;
    r.slot   = slot[3:0];
    r.hits   = shadow_hits;
    r.faults = shadow_faults;
    return r;
  endfunction

  // Random gaps, with one quiet window per period where nobody stalls
  function automatic bit take_break();
    return (cyc % 3000 >= 500) && ($urandom_range(0, 99) < 22);
  endfunction

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    outcome_t want;
    cyc++;
    if (!rst && s_tvalid && s_tready) begin
      outcome_q.insert(outcome_q.size(), replace_page(s_tdata[15:0], s_tdata[16],
                                                      s_tuser[0]));
      req_taken = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser[0]) hits_seen++;
      if (outcome_q.size() == 0) begin
        $error("result with no request outstanding: hit=%0b slot=%0d", m_tuser[0],
               m_tdata[3:0]);
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        if (m_tuser[0] !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, m_tuser[0]);
          fail_count++;
        end
        if (m_tdata[3:0] !== want.slot) begin
          $error("frame_slot: expected %0d, got %0d", want.slot, m_tdata[3:0]);
          fail_count++;
        end
        if (m_tdata[35:4] !== want.hits) begin
          $error("hit_count: expected %0d, got %0d", want.hits, m_tdata[35:4]);
          fail_count++;
        end
        if (m_tdata[67:36] !== want.faults) begin
          $error("fault_count: expected %0d, got %0d", want.faults, m_tdata[67:36]);
          fail_count++;
        end
      end
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d results outstanding", idle_cycles,
               outcome_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Feed requests; hold each until it is taken
  always @(negedge clk) begin
    page_ref_t nxt;
    if (!rst && (!s_tvalid || req_taken)) begin
      req_taken = 1'b0;
      if (pending_refs.size() > 0 && !take_break()) begin
        nxt = pending_refs.pop_front();
        s_tdata  <= {7'd0, nxt.mod, nxt.page};
        s_tuser  <= nxt.fresh;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    m_tready <= !rst && !take_break();
  end

  task automatic queue_ref(input logic [15:0] page, input logic mod, input logic fresh);
    page_ref_t r;
    r.page  = page;
    r.mod   = mod;
    r.fresh = fresh;
    pending_refs.insert(pending_refs.size(), r);
  endtask

  // Wait until every queued request has been taken and answered
  task automatic drain();
    while (pending_refs.size() != 0 || s_tvalid || outcome_q.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  // One register access: setup cycle, then access cycle
  task automatic cfg_access(input bit wr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= FRAMES_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the frame count, read it back and track it
  task automatic set_frames(input logic [4:0] value);
    logic [31:0] rd;
    cfg_access(1'b1, {27'd0, value}, rd);
    frames_cfg = value;
    settings_used++;
    cfg_access(1'b0, '0, rd);
    if (rd !== {27'd0, value}) begin
      $error("frames_in_use readback: expected %0d, got %0d", value, rd);
      fail_count++;
    end
  endtask

  initial begin
    logic [4:0]  settings [12];
    logic [31:0] rd;
    logic [15:0] pool_base;
    logic [15:0] page;
    int act;
    int span;
    settings = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd4, 5'd8, 5'd2, 5'd3, 5'd12,
                 5'd16, 5'd7};
    for (int f = 0; f < FRAMES; f++) begin
      shadow_valid[f] = 1'b0;
      shadow_ref[f]   = 1'b0;
      shadow_mod[f]   = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Check the frame count after reset
    cfg_access(1'b0, '0, rd);
    if (rd !== {27'd0, FRAMES_RESET}) begin
      $error("frames_in_use after reset: expected %0d, got %0d", FRAMES_RESET, rd);
      fail_count++;
    end

    // Full table: page extremes, hit while filling
    set_frames(5'd16);
    queue_ref(16'h0000, 1'b0, 1'b0);
    queue_ref(16'hFFFF, 1'b1, 1'b0);
    queue_ref(16'h0000, 1'b1, 1'b0);
    queue_ref(16'h8000, 1'b0, 1'b0);
    drain();

    // Four frames: restart, fill, then sweep past used frames
    set_frames(5'd4);
    queue_ref(16'd1, 1'b0, 1'b1);
    queue_ref(16'd2, 1'b1, 1'b0);
    queue_ref(16'd3, 1'b0, 1'b0);
    queue_ref(16'd4, 1'b0, 1'b0);
    queue_ref(16'd1, 1'b0, 1'b0);
    queue_ref(16'd5, 1'b0, 1'b0);
    queue_ref(16'd3, 1'b1, 1'b0);
    queue_ref(16'd6, 1'b1, 1'b0);
    queue_ref(16'd7, 1'b0, 1'b0);
    queue_ref(16'd8, 1'b0, 1'b0);
    queue_ref(16'hFFFF, 1'b1, 1'b1);
    queue_ref(16'd9, 1'b1, 1'b0);
    queue_ref(16'd10, 1'b0, 1'b0);
    drain();

    // Shrink mid-trace: hand wraps, upper frames ignored
    set_frames(5'd2);
    queue_ref(16'd10, 1'b0, 1'b0);
    queue_ref(16'd11, 1'b0, 1'b0);
    queue_ref(16'd11, 1'b1, 1'b0);
    drain();

    // Zero acts as one frame
    set_frames(5'd0);
    queue_ref(16'd12, 1'b1, 1'b0);
    queue_ref(16'd12, 1'b0, 1'b0);
    drain();

    // Oversized count acts as all frames; filling resumes
    set_frames(5'd31);
    queue_ref(16'd13, 1'b0, 1'b0);
    queue_ref(16'd14, 1'b1, 1'b0);
    drain();

    // Random phases over a small page pool, with some stray pages and restarts
    foreach (settings[p]) begin
      set_frames(settings[p]);
      act = (settings[p] == 0) ? 1 : (settings[p] > FRAMES) ? FRAMES : int'(settings[p]);
      pool_base = 16'($urandom);
      span = act + $urandom_range(1, act + 3);
      for (int k = 0; k < PHASE_REFS; k++) begin
        if ($urandom_range(0, 99) < 10) page = 16'($urandom);
        else page = pool_base + 16'($urandom_range(0, span - 1));
        queue_ref(page, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 3);
      end
      drain();
    end

    // Let any stray result show up
    repeat (20) @(posedge clk);
    if (outcome_q.size() != 0) begin
      $error("%0d results never arrived", outcome_q.size());
      fail_count++;
    end
    $display("Checked %0d results under %0d frame counts: %0d hits, %0d faults",
             results_seen, settings_used, hits_seen, results_seen - hits_seen);
    $display("Replacement sweeps: %0d, trace restarts: %0d", sweeps, restarts);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
